@@ rtl/bps_pkg.sv @@
package bps_pkg;

    localparam int MAX_HOSTS_DEF  = 256;

    localparam int FRAC_BITS      = 16;
    localparam int RATIO_W        = 21;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 21'h100000;
    localparam int DELTA_W        = 22;
    localparam int HOST_W         = 8;

    localparam int CPU_LIM_W      = 17;
    localparam int CPU_USE_W      = 16;
    localparam int MEM_LIM_W      = 33;
    localparam int MEM_USE_W      = 32;
    localparam int LOAD_W         = 24;
    localparam int CORES_W        = 11;
    localparam int CPU_SUM_W      = 25;
    localparam int CPU_DEN_W      = 21;
    localparam int MILLI_PER_CORE = 1000;

    // Divider operands: dividend is the widest usage sum, divisor the memory size.
    localparam int NUM_W          = 33;
    localparam int DEN_W          = 32;
    // Two quotient bits per step; 22 bits cover every unsaturated ratio.
    localparam int QUO_W          = 22;
    localparam int DIV_STEPS      = QUO_W / 2;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [RATIO_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_PREP      = 6'b000010,
        S_DIV_START = 6'b000100,
        S_DIV_WAIT  = 6'b001000,
        S_SCORE     = 6'b010000,
        S_UPD       = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        SEL_CPU_BEFORE = 2'd0,
        SEL_MEM_BEFORE = 2'd1,
        SEL_CPU_AFTER  = 2'd2,
        SEL_MEM_AFTER  = 2'd3
    } t_div_sel;

endpackage

@@ rtl/bps_chan_if.sv @@
interface bps_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bps_pkg::CPU_LIM_W-1:0]   unit_cpu_limit;
    logic        [bps_pkg::CPU_USE_W-1:0]   unit_cpu_usage;
    logic signed [bps_pkg::MEM_LIM_W-1:0]   unit_mem_limit;
    logic        [bps_pkg::MEM_USE_W-1:0]   unit_mem_usage;
    logic        [bps_pkg::LOAD_W-1:0]      host_load;
    logic        [bps_pkg::CORES_W-1:0]     host_cores;
    logic        [bps_pkg::MEM_USE_W-1:0]   host_mem_used;
    logic        [bps_pkg::MEM_USE_W-1:0]   host_mem_size;
    logic                                   final_host;

    modport source (
        output valid, unit_cpu_limit, unit_cpu_usage, unit_mem_limit, unit_mem_usage,
               host_load, host_cores, host_mem_used, host_mem_size, final_host,
        input  ready
    );
    modport sink (
        input  valid, unit_cpu_limit, unit_cpu_usage, unit_mem_limit, unit_mem_usage,
               host_load, host_cores, host_mem_used, host_mem_size, final_host,
        output ready
    );
endinterface

interface bps_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [bps_pkg::HOST_W-1:0]    chosen_host;
    logic signed [bps_pkg::DELTA_W-1:0]   chosen_delta;

    modport source (
        output valid, chosen_host, chosen_delta,
        input  ready
    );
    modport sink (
        input  valid, chosen_host, chosen_delta,
        output ready
    );
endinterface

@@ rtl/bps_div.sv @@
module bps_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bps_pkg::t_div_req i_req,
    output bps_pkg::t_div_rsp o_rsp
);

    localparam int DEN_W   = bps_pkg::DEN_W;
    localparam int QUO_W   = bps_pkg::QUO_W;
    localparam int RATIO_W = bps_pkg::RATIO_W;
    localparam int FRAC_W  = bps_pkg::FRAC_BITS;
    localparam int LOW_W   = QUO_W - FRAC_W;
    localparam int SAT_SH  = RATIO_W - FRAC_W;
    localparam int STEP_W  = $clog2(bps_pkg::DIV_STEPS);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DEN_W-1:0]   r_rem,  n_rem;
    logic [DEN_W-1:0]   r_den,  n_den;
    logic [QUO_W-1:0]   r_quo,  n_quo;
    logic [QUO_W-1:0]   r_bits, n_bits;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [RATIO_W-1:0] r_res,  n_res;

    logic [DEN_W:0]     w_t1, w_t2;
    logic [DEN_W-1:0]   w_rem1, w_rem2;
    logic               w_q1, w_q2;
    logic [QUO_W-1:0]   w_quo;
    logic               w_sat;

    // Two restoring steps per cycle; each partial remainder stays below the divisor.
    always_comb begin
        w_t1   = {r_rem, r_bits[QUO_W-1]};
        w_q1   = (w_t1 >= {1'b0, r_den});
        w_rem1 = w_q1 ? DEN_W'(w_t1 - {1'b0, r_den}) : w_t1[DEN_W-1:0];
        w_t2   = {w_rem1, r_bits[QUO_W-2]};
        w_q2   = (w_t2 >= {1'b0, r_den});
        w_rem2 = w_q2 ? DEN_W'(w_t2 - {1'b0, r_den}) : w_t2[DEN_W-1:0];
        w_quo  = {r_quo[QUO_W-3:0], w_q1, w_q2};
    end

    // The quotient would not fit its bits when num is at least 32 times den.
    assign w_sat = (i_req.den == '0) ||
                   ({{SAT_SH{1'b0}}, i_req.num} >= {1'b0, i_req.den, {SAT_SH{1'b0}}});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_bits = r_bits;
        n_step = r_step;
        n_res  = r_res;
        if (i_req.start) begin
            if (w_sat) begin
                n_done = 1'b1;
                n_res  = bps_pkg::RATIO_MAX;
            end else begin
                n_busy = 1'b1;
                n_den  = i_req.den;
                n_rem  = DEN_W'(i_req.num >> LOW_W);
                n_bits = {i_req.num[LOW_W-1:0], {FRAC_W{1'b0}}};
                n_quo  = '0;
                n_step = STEP_W'(bps_pkg::DIV_STEPS - 1);
            end
        end else if (r_busy) begin
            n_rem  = w_rem2;
            n_quo  = w_quo;
            n_bits = r_bits << 2;
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (w_quo > QUO_W'(bps_pkg::RATIO_MAX)) begin
                    n_res = bps_pkg::RATIO_MAX;
                end else begin
                    n_res = w_quo[RATIO_W-1:0];
                end
            end else begin
                n_step = r_step - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_bits <= n_bits;
        r_step <= n_step;
        r_res  <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_res;

endmodule

@@ rtl/balanced_placement_selector.sv @@
// Channel   Direction  Payload
// i_in      in         workload demand and one candidate server, final_host marker
// o_out     out        chosen_host, chosen_delta (one beat per placement)
//
// Each server beat runs four saturating divisions that share one radix-4 divider
// of 11 steps, each with a start and a wait state, plus the idle, prep, score and
// update states; the next server is accepted only back in idle. A division that
// saturates skips the steps and answers in the cycle after its start.
// Reset clears the sequencer, the running choice and the output valid.
// A result waits in the output register; only a final beat that finds it still
// untaken holds the sequencer until o_out.ready.
module balanced_placement_selector #(
    parameter int MAX_HOSTS = bps_pkg::MAX_HOSTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bps_in_if.sink           i_in,
    bps_out_if.source        o_out
);

    localparam int CNT_W   = $clog2(MAX_HOSTS);
    localparam int HOST_W  = bps_pkg::HOST_W;
    localparam int DELTA_W = bps_pkg::DELTA_W;
    localparam int RATIO_W = bps_pkg::RATIO_W;
    localparam int NUM_W   = bps_pkg::NUM_W;
    localparam int DEN_W   = bps_pkg::DEN_W;

    bps_pkg::t_state   r_state, n_state;
    bps_pkg::t_div_sel r_sel,   n_sel;

    logic [bps_pkg::LOAD_W-1:0]    r_load;
    logic [bps_pkg::CORES_W-1:0]   r_cores;
    logic [bps_pkg::MEM_USE_W-1:0] r_mused;
    logic [bps_pkg::MEM_USE_W-1:0] r_msize;
    logic [bps_pkg::CPU_USE_W-1:0] r_ucpu;
    logic [bps_pkg::MEM_USE_W-1:0] r_umem;
    logic                          r_last;
    logic [bps_pkg::CPU_DEN_W-1:0] r_cpu_den;
    logic [bps_pkg::CPU_SUM_W-1:0] r_cpu_sum;
    logic [NUM_W-1:0]              r_mem_sum;

    logic [RATIO_W-1:0] r_q [4];
    logic [RATIO_W-1:0] r_before, r_after;

    logic signed [DELTA_W-1:0] r_best;
    logic [CNT_W-1:0]          r_best_idx;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_seen;

    logic                      r_out_valid;
    logic [HOST_W-1:0]         r_out_host;
    logic signed [DELTA_W-1:0] r_out_delta;

    logic [bps_pkg::CPU_USE_W-1:0] w_ucpu;
    logic [bps_pkg::MEM_USE_W-1:0] w_umem;
    logic signed [DELTA_W-1:0]     w_delta;
    logic [CNT_W+HOST_W-1:0]       w_idx_ext;
    logic                          w_take;
    logic                          w_out_busy;
    bps_pkg::t_div_req             w_req;
    bps_pkg::t_div_rsp             w_rsp;

    bps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_in.ready = (r_state == bps_pkg::S_IDLE);

    // An all-ones limit selects usage; any other negative limit counts as zero.
    always_comb begin
        if (&i_in.unit_cpu_limit) begin
            w_ucpu = i_in.unit_cpu_usage;
        end else if (i_in.unit_cpu_limit[bps_pkg::CPU_LIM_W-1]) begin
            w_ucpu = '0;
        end else begin
            w_ucpu = i_in.unit_cpu_limit[bps_pkg::CPU_USE_W-1:0];
        end
        if (&i_in.unit_mem_limit) begin
            w_umem = i_in.unit_mem_usage;
        end else if (i_in.unit_mem_limit[bps_pkg::MEM_LIM_W-1]) begin
            w_umem = '0;
        end else begin
            w_umem = i_in.unit_mem_limit[bps_pkg::MEM_USE_W-1:0];
        end
    end

    always_comb begin
        w_req.start = (r_state == bps_pkg::S_DIV_START);
        case (r_sel)
            bps_pkg::SEL_CPU_BEFORE: begin
                w_req.num = NUM_W'(r_load);
                w_req.den = DEN_W'(r_cpu_den);
            end
            bps_pkg::SEL_MEM_BEFORE: begin
                w_req.num = NUM_W'(r_mused);
                w_req.den = r_msize;
            end
            bps_pkg::SEL_CPU_AFTER: begin
                w_req.num = NUM_W'(r_cpu_sum);
                w_req.den = DEN_W'(r_cpu_den);
            end
            default: begin
                w_req.num = r_mem_sum;
                w_req.den = r_msize;
            end
        endcase
    end

    assign w_delta    = DELTA_W'({1'b0, r_after}) - DELTA_W'({1'b0, r_before});
    assign w_take     = !r_seen || (w_delta < r_best);
    assign w_idx_ext  = {{HOST_W{1'b0}}, (w_take ? r_cnt : r_best_idx)};
    assign w_out_busy = r_out_valid && !o_out.ready;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        case (r_state)
            bps_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = bps_pkg::S_PREP;
                end
            end
            bps_pkg::S_PREP: begin
                n_sel   = bps_pkg::SEL_CPU_BEFORE;
                n_state = bps_pkg::S_DIV_START;
            end
            bps_pkg::S_DIV_START: begin
                n_state = bps_pkg::S_DIV_WAIT;
            end
            bps_pkg::S_DIV_WAIT: begin
                if (w_rsp.done) begin
                    case (r_sel)
                        bps_pkg::SEL_CPU_BEFORE: begin
                            n_sel   = bps_pkg::SEL_MEM_BEFORE;
                            n_state = bps_pkg::S_DIV_START;
                        end
                        bps_pkg::SEL_MEM_BEFORE: begin
                            n_sel   = bps_pkg::SEL_CPU_AFTER;
                            n_state = bps_pkg::S_DIV_START;
                        end
                        bps_pkg::SEL_CPU_AFTER: begin
                            n_sel   = bps_pkg::SEL_MEM_AFTER;
                            n_state = bps_pkg::S_DIV_START;
                        end
                        default: begin
                            n_state = bps_pkg::S_SCORE;
                        end
                    endcase
                end
            end
            bps_pkg::S_SCORE: begin
                n_state = bps_pkg::S_UPD;
            end
            bps_pkg::S_UPD: begin
                if (!(r_last && w_out_busy)) begin
                    n_state = bps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bps_pkg::S_IDLE;
            r_sel       <= bps_pkg::SEL_CPU_BEFORE;
            r_best      <= '0;
            r_best_idx  <= '0;
            r_cnt       <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            if (r_state == bps_pkg::S_UPD && r_last && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == bps_pkg::S_UPD && !(r_last && w_out_busy)) begin
                if (r_last) begin
                    // The placement ends here: publish the choice and start over.
                    r_out_host  <= w_idx_ext[HOST_W-1:0];
                    r_out_delta <= w_take ? w_delta : r_best;
                    r_best      <= '0;
                    r_best_idx  <= '0;
                    r_cnt       <= '0;
                    r_seen      <= 1'b0;
                end else begin
                    if (w_take) begin
                        r_best     <= w_delta;
                        r_best_idx <= r_cnt;
                    end
                    r_seen <= 1'b1;
                    if (r_cnt < CNT_W'(MAX_HOSTS - 1)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end
        end

        if (i_in.valid && i_in.ready) begin
            r_load  <= i_in.host_load;
            r_cores <= i_in.host_cores;
            r_mused <= i_in.host_mem_used;
            r_msize <= i_in.host_mem_size;
            r_ucpu  <= w_ucpu;
            r_umem  <= w_umem;
            r_last  <= i_in.final_host;
        end
        if (r_state == bps_pkg::S_PREP) begin
            r_cpu_den <= bps_pkg::CPU_DEN_W'(r_cores) *
                         bps_pkg::CPU_DEN_W'(bps_pkg::MILLI_PER_CORE);
            r_cpu_sum <= bps_pkg::CPU_SUM_W'(r_load) + bps_pkg::CPU_SUM_W'(r_ucpu);
            r_mem_sum <= NUM_W'(r_mused) + NUM_W'(r_umem);
        end
        if (r_state == bps_pkg::S_DIV_WAIT && w_rsp.done) begin
            r_q[r_sel] <= w_rsp.quo;
        end
        if (r_state == bps_pkg::S_SCORE) begin
            r_before <= (r_q[0] >= r_q[1]) ? (r_q[0] - r_q[1]) : (r_q[1] - r_q[0]);
            r_after  <= (r_q[2] >= r_q[3]) ? (r_q[2] - r_q[3]) : (r_q[3] - r_q[2]);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.chosen_host  = r_out_host;
    assign o_out.chosen_delta = r_out_delta;

    // The divider only answers a request that the sequencer is waiting on.
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == bps_pkg::S_DIV_WAIT))
        else $error("divider done outside of its wait state");

    // The server count and the seen flag move together.
    a_seen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen == (r_cnt != '0)))
        else $error("server count disagrees with seen flag");

    // A final server always yields a result beat and a cleared choice.
    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bps_pkg::S_UPD && r_last && !w_out_busy)
        |=> (r_out_valid && !r_seen && r_state == bps_pkg::S_IDLE))
        else $error("final server did not produce a result");

endmodule
